// ===== sv/binary_fsk_tone_generator_defines.svh =====
// Assertion macros shared by the FSK tone generator RTL.
// Both expect clk and rst_n in scope.
`ifndef BINARY_FSK_TONE_GENERATOR_DEFINES_SVH
`define BINARY_FSK_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication
`define FSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fsk_pkg.sv =====
package fsk_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS    = 16;
    localparam int CNT_BITS       = 16;
    localparam int STEP_BITS      = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Configuration reset values
    localparam logic [CNT_BITS-1:0]  SAMPLES_PER_BIT_RESET = 16'd4410;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_ZERO_RESET = 32'd97391549;
    localparam logic [STEP_BITS-1:0] PHASE_STEP_ONE_RESET  = 32'd194783097;

    // Sine table constants: pi/2 in Q30, full scale of the sample
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] FULL_SCALE  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    // Register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SAMPLES_PER_BIT = 2'd0,
        CFG_PHASE_STEP_ZERO = 2'd1,
        CFG_PHASE_STEP_ONE  = 2'd2
    } cfg_index_t;

    // Request payloads
    typedef struct packed {
        logic bit_value;
        logic final_bit;
    } fsk_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          bit_done;
        logic                          message_done;
    } fsk_out_t;

    // Quarter-wave table entry: Taylor series to x^13 in unsigned Q30,
    // scaled to full scale, rounded half up and clamped. Elaboration only.
    function automatic logic [SAMPLE_BITS-2:0] quarter_sine(input int unsigned idx,
                                                            input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (64'(idx) * HALF_PI_Q30) >> qbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        v = (sum * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return v[SAMPLE_BITS-2:0];
    endfunction

endpackage

// ===== sv/fsk_sine_lut.sv =====
module fsk_sine_lut
    import fsk_pkg::*;
#(
    parameter int TABLE_BITS = 10
)
(
    input  logic [TABLE_BITS-1:0]         addr,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int QUARTER_BITS = TABLE_BITS - 2;
    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;

    // Quarter-wave constant table, endpoints included
    logic [SAMPLE_BITS-2:0] rom [0:QUARTER_SIZE];

    for (genvar g = 0; g <= QUARTER_SIZE; g++)
    begin : g_rom
        assign rom[g] = quarter_sine(g, QUARTER_BITS);
    end

    logic [1:0]              quad;
    logic [QUARTER_BITS-1:0] offset;
    logic [QUARTER_BITS:0]   rom_idx;
    logic [SAMPLE_BITS-2:0]  mag;
    logic [SAMPLE_BITS-1:0]  mag_ext;

    // Mirror odd quadrants, negate the lower half-wave
    always_comb
    begin
        quad    = addr[TABLE_BITS-1 -: 2];
        offset  = addr[QUARTER_BITS-1:0];
        rom_idx = quad[0] ? ((QUARTER_BITS + 1)'(QUARTER_SIZE) - {1'b0, offset})
                          : {1'b0, offset};
        mag     = rom[rom_idx];
        mag_ext = {1'b0, mag};
        sample  = quad[1] ? -$signed(mag_ext) : $signed(mag_ext);
    end

endmodule

// ===== sv/fsk_out_buf.sv =====
module fsk_out_buf
    import fsk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fsk_out_t push_data,
    output logic     full,
    output logic     out_valid,
    input  logic     out_stall,
    output fsk_out_t out_data
);

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    fsk_out_t out_data_reg, out_data_next;
    fsk_out_t skid_data_reg, skid_data_next;
    logic     out_free;

    // Output register plus one skid entry; full is a pure register
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== sv/binary_fsk_tone_generator.sv =====
// Binary FSK tone generator: one audio sample per accepted request.
// Each result is registered; while the output stalls it waits in the skid entry.
// Throughput: one request per cycle unless the skid entry is full; the phase add
// and the sine table lookup sit between the input and the output register.
// Reset (rst_n, async, active low) clears window count, phase and held bit,
// empties the output, and loads 4410 samples per bit and 1 kHz / 2 kHz steps.
`include "binary_fsk_tone_generator_defines.svh"

module binary_fsk_tone_generator
    import fsk_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  fsk_in_t                   in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output fsk_out_t                  out_data
);

    logic [CNT_BITS-1:0]   spb_reg;
    logic [STEP_BITS-1:0]  step_zero_reg;
    logic [STEP_BITS-1:0]  step_one_reg;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic                  held_bit_reg, held_bit_next;
    logic                  held_final_reg, held_final_next;

    logic                  accept_in;
    logic                  first;
    logic [CNT_BITS-1:0]   window;
    logic [CNT_BITS:0]     cnt_inc;
    logic                  last;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [STEP_BITS-1:0]  step;
    logic signed [SAMPLE_BITS-1:0] lut_sample;
    fsk_out_t              result;
    logic                  buf_full;

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = buf_full;

    // Configuration write decode; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg       <= SAMPLES_PER_BIT_RESET;
            step_zero_reg <= PHASE_STEP_ZERO_RESET;
            step_one_reg  <= PHASE_STEP_ONE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SAMPLES_PER_BIT: spb_reg       <= cfg_data[CNT_BITS-1:0];
                CFG_PHASE_STEP_ZERO: step_zero_reg <= cfg_data[STEP_BITS-1:0];
                CFG_PHASE_STEP_ONE:  step_one_reg  <= cfg_data[STEP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Window tracking and phase accumulation
    always_comb
    begin
        first           = (cnt_reg == '0);
        window          = (spb_reg == '0) ? CNT_BITS'(1) : spb_reg;
        held_bit_next   = first ? in_data.bit_value : held_bit_reg;
        held_final_next = first ? in_data.final_bit : held_final_reg;
        cur_phase       = first ? '0 : phase_reg;
        step            = held_bit_next ? step_one_reg : step_zero_reg;
        phase_next      = cur_phase + step[STEP_BITS-1 -: PHASE_BITS];
        cnt_inc         = {1'b0, cnt_reg} + (CNT_BITS + 1)'(1);
        last            = (cnt_inc >= {1'b0, window});
        cnt_next        = last ? '0 : cnt_inc[CNT_BITS-1:0];
    end

    // Sample from the phase before the increment
    fsk_sine_lut #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_lut (
        .addr   (cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
        .sample (lut_sample)
    );

    always_comb
    begin
        result.sample       = lut_sample;
        result.bit_done     = last;
        result.message_done = last && held_final_next;
    end

    // Tone state, updated once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            phase_reg      <= '0;
            held_bit_reg   <= 1'b0;
            held_final_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            cnt_reg        <= cnt_next;
            phase_reg      <= phase_next;
            held_bit_reg   <= held_bit_next;
            held_final_reg <= held_final_next;
        end
    end

    // Result register with skid entry
    fsk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept_in),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Checks
    `FSK_ASSERT_NOW(a_msg_implies_bit, out_valid && out_data.message_done,
        out_data.bit_done, "message_done without bit_done")
    `FSK_ASSERT_NOW(a_skid_behind_out, in_stall, out_valid,
        "skid entry held while output register empty")
    `FSK_ASSERT_NEXT(a_bit_latched, accept_in && (cnt_reg == '0),
        held_bit_reg == $past(in_data.bit_value), "bit not latched at window start")

endmodule

// ===== tb/fsk_tone_checker.sv =====
module fsk_tone_checker
    import fsk_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  fsk_in_t                   in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  fsk_out_t                  out_data,
    output int                        fail_count,
    output int                        pending,
    output int                        sample_count,
    output int                        window_count,
    output int                        message_count
);

    localparam int     QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int     QUARTER      = 1 << QUARTER_BITS;
    localparam longint PEAK         = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;

    // Quarter-wave magnitudes, built once
    logic [SAMPLE_BITS-1:0] quarter_wave [0:QUARTER];

    // Own copy of the registers and the modulator state
    logic [CNT_BITS-1:0]   window_len;
    logic [STEP_BITS-1:0]  step_for_zero;
    logic [STEP_BITS-1:0]  step_for_one;
    logic [CNT_BITS-1:0]   pos_in_window;
    logic [PHASE_BITS-1:0] tone_acc;
    logic                  tone_bit;
    logic                  tone_last_bit;

    fsk_out_t expected_samples[$];
    int       mismatches;
    int       n_samples;
    int       n_windows;
    int       n_messages;

    // Taylor series to x^13 in unsigned Q30, scaled and rounded half up
    function automatic logic [SAMPLE_BITS-1:0] sine_magnitude(input int unsigned idx);
        longint unsigned x;
        longint unsigned x_sq;
        longint unsigned term;
        longint          acc;
        longint          level;
        int              k;
        x    = (longint'(idx) * HALF_PI_Q30) / longint'(QUARTER);
        x_sq = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (k = 1; k <= 6; k++)
        begin
            term = (term * x_sq) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        level = (acc * PEAK + (64'sd1 <<< 29)) >>> 30;
        if (level > PEAK)
            level = PEAK;
        return level[SAMPLE_BITS-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i <= QUARTER; i++)
            quarter_wave[i] = sine_magnitude(i);
    end

    // Phase to signed level: top table bits address, top two pick the quadrant
    function automatic logic signed [SAMPLE_BITS-1:0] phase_to_level(
        input logic [PHASE_BITS-1:0] phase);
        logic [SAMPLE_BITS-1:0] mag;
        logic [1:0]             quad;
        int unsigned            offset;
        quad   = phase[PHASE_BITS-1 -: 2];
        offset = 32'(phase[PHASE_BITS-3 -: QUARTER_BITS]);
        mag    = quad[0] ? quarter_wave[QUARTER - offset] : quarter_wave[offset];
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Advance the modulator by one request and queue the sample it gives
    task automatic predict_sample(input fsk_in_t req);
        logic [CNT_BITS:0]    span;
        logic [STEP_BITS-1:0] step;
        fsk_out_t             want;
        logic                 last;
        span = (window_len == '0) ? (CNT_BITS + 1)'(1) : {1'b0, window_len};
        if (pos_in_window == '0)
        begin
            tone_bit      = req.bit_value;
            tone_last_bit = req.final_bit;
            tone_acc      = '0;
        end
        want.sample   = phase_to_level(tone_acc);
        step          = tone_bit ? step_for_one : step_for_zero;
        tone_acc      = tone_acc + step[STEP_BITS-1 -: PHASE_BITS];
        last          = ({1'b0, pos_in_window} + 1) >= span;
        pos_in_window = last ? '0 : pos_in_window + 1'b1;
        want.bit_done     = last;
        want.message_done = last && tone_last_bit;
        n_samples++;
        if (last)
            n_windows++;
        if (want.message_done)
            n_messages++;
        expected_samples.push_back(want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fsk_out_t want;
        if (!rst_n)
        begin
            window_len    = SAMPLES_PER_BIT_RESET;
            step_for_zero = PHASE_STEP_ZERO_RESET;
            step_for_one  = PHASE_STEP_ONE_RESET;
            pos_in_window = '0;
            tone_acc      = '0;
            tone_bit      = 1'b0;
            tone_last_bit = 1'b0;
            expected_samples.delete();
            mismatches = 0;
            n_samples  = 0;
            n_windows  = 0;
            n_messages = 0;
        end
        else
        begin
            // Register writes; unknown indexes are ignored
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SAMPLES_PER_BIT: window_len    = cfg_data[CNT_BITS-1:0];
                    CFG_PHASE_STEP_ZERO: step_for_zero = cfg_data[STEP_BITS-1:0];
                    CFG_PHASE_STEP_ONE:  step_for_one  = cfg_data[STEP_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_sample(in_data);
            // Compare each delivered sample with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("sample delivered with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_data.sample !== want.sample)
                    begin
                        $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
                        mismatches++;
                    end
                    if (out_data.bit_done !== want.bit_done)
                    begin
                        $error("bit_done: expected %0b, got %0b",
                               want.bit_done, out_data.bit_done);
                        mismatches++;
                    end
                    if (out_data.message_done !== want.message_done)
                    begin
                        $error("message_done: expected %0b, got %0b",
                               want.message_done, out_data.message_done);
                        mismatches++;
                    end
                end
            end
        end
        fail_count    <= mismatches;
        pending       <= expected_samples.size();
        sample_count  <= n_samples;
        window_count  <= n_windows;
        message_count <= n_messages;
    end

endmodule

// ===== tb/binary_fsk_tone_generator_tb.sv =====
module binary_fsk_tone_generator_tb;
    import fsk_pkg::*;

    localparam int STUCK_LIMIT = 5000;
    localparam int SETTINGS_RUN = 8;
    localparam int ITEMS_PER_SETTING = 125;
    localparam int LONG_WINDOW_ITEMS = 64;
    // Index past the last register; writes to it must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    fsk_in_t                   in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    fsk_out_t                  out_data;

    int fail_count;
    int pending;
    int sample_count;
    int window_count;
    int message_count;

    int idle_pct  = 0;
    int stall_pct = 0;
    int cur_window = int'(SAMPLES_PER_BIT_RESET);
    int stuck_cycles = 0;

    binary_fsk_tone_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    fsk_tone_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .sample_count  (sample_count),
        .window_count  (window_count),
        .message_count (message_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: too long with no request moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one request, after a random gap, and hold it until taken
    task automatic send_item(input logic bit_value, input logic final_bit);
        fsk_in_t req;
        req.bit_value = bit_value;
        req.final_bit = final_bit;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding sample
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_SAMPLES_PER_BIT)
            cur_window = (value[CNT_BITS-1:0] == '0) ? 1 : int'(value[CNT_BITS-1:0]);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [STEP_BITS-1:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else if (r < 30)
            return 32'h4000_0000;
        return $urandom();
    endfunction

    // Messages of whole bit windows: the first sample of each window carries
    // the bit and the final mark, the rest carry ignored noise.
    task automatic run_messages(input int count);
        int n;
        int pos;
        int bits_left;
        logic bit_value;
        logic final_bit;
        n = 0;
        pos = 0;
        bits_left = 0;
        while (n < count || pos != 0)
        begin
            if (pos == 0)
            begin
                if (bits_left == 0)
                    bits_left = $urandom_range(1, 8);
                bits_left--;
                bit_value = 1'($urandom_range(1));
                final_bit = ($urandom_range(9) == 0) ? 1'($urandom_range(1))
                                                     : (bits_left == 0);
            end
            else
            begin
                bit_value = 1'($urandom_range(1));
                final_bit = 1'($urandom_range(1));
            end
            send_item(bit_value, final_bit);
            pos = (pos + 1 >= cur_window) ? 0 : pos + 1;
            n++;
        end
    endtask

    initial
    begin
        int mode;
        int r;
        logic [CNT_BITS-1:0] spb;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: a 1 bit at the default 2 kHz step, mid-window noise
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b1);
        quiesce();

        // Zero window length acts as one sample per window
        write_reg(CFG_SAMPLES_PER_BIT, {16'hA5C3, 16'd0});
        write_reg(CFG_PHASE_STEP_ZERO, 32'h4000_0000);
        write_reg(CFG_PHASE_STEP_ONE, 32'hFFFF_FFFF);
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        quiesce();

        // Quarter-turn steps land on every quadrant edge; unused index ignored
        write_reg(CFG_SAMPLES_PER_BIT, 32'd5);
        write_reg(CFG_UNUSED_INDEX, 32'h0000_0001);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b0, 1'b0);
        send_item(1'b1, 1'b1);
        send_item(1'b0, 1'b0);
        quiesce();

        // Random settings, two per idling mix
        for (int s = 0; s < SETTINGS_RUN; s++)
        begin
            mode = s / 2;
            idle_pct  = (mode == 1) ? 86 : (mode == 3) ? 6 : 0;
            stall_pct = (mode == 2) ? 86 : (mode == 3) ? 6 : 0;
            r = $urandom_range(99);
            if (r < 15)
                spb = '0;
            else if (r < 80)
                spb = CNT_BITS'($urandom_range(1, 6));
            else
                spb = CNT_BITS'($urandom_range(7, 40));
            write_reg(CFG_SAMPLES_PER_BIT, {16'($urandom()), spb});
            if (s == 0)
            begin
                write_reg(CFG_PHASE_STEP_ZERO, 32'hFFFF_FFFF);
                write_reg(CFG_PHASE_STEP_ONE, 32'h0);
            end
            else
            begin
                write_reg(CFG_PHASE_STEP_ZERO, pick_step());
                write_reg(CFG_PHASE_STEP_ONE, pick_step());
            end
            run_messages(ITEMS_PER_SETTING);
            quiesce();
        end

        // Longest window, run at full rate for a short stretch of it
        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_SAMPLES_PER_BIT, 32'h0000_FFFF);
        write_reg(CFG_PHASE_STEP_ZERO, $urandom());
        write_reg(CFG_PHASE_STEP_ONE, $urandom());
        repeat (LONG_WINDOW_ITEMS)
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        quiesce();

        $display("Covered %0d samples in %0d bit windows, %0d messages flagged complete;",
                 sample_count, window_count, message_count);
        $display("window lengths 0 to 65535, step extremes, four idle/stall mixes.");
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
